FILE: rtl/rtef_pkg.sv
// Package for the ramped trap exposure fraction block.
// Holds widths, result codes, register indexes and the sideband struct.
// No dependencies; every rtl file imports it.
package rtef_pkg;

   // fixed point format: FRAC_BITS fraction bits, one integer bit
   localparam int FRAC_BITS = 16;
   localparam int VAL_W     = FRAC_BITS + 1;
   localparam int NUM_W     = 2 * VAL_W;
   localparam int DIV_W     = FRAC_BITS + 2;
   localparam int QUO_W     = FRAC_BITS + 1;
   localparam int CSR_IDX_W = 2;

   localparam logic [VAL_W-1:0] ONE_VAL = VAL_W'(1) << FRAC_BITS;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_NONE_EXPOSED = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_FULL_EXPOSED = CSR_IDX_W'(1);

   // classification of a transaction
   typedef logic [2:0] code_type;
   localparam code_type CODE_FULL  = 3'd0;
   localparam code_type CODE_NONE  = 3'd1;
   localparam code_type CODE_EMPTY = 3'd2;
   localparam code_type CODE_STEP  = 3'd3;
   localparam code_type CODE_RAMP  = 3'd4;

   // data that travels beside the dividers
   typedef struct packed {
      code_type          code;
      logic [VAL_W-1:0]  hb;    // part of the interval above full exposure
      logic [VAL_W-1:0]  dlen;  // interval width, high - low
   } side_type;

endpackage

FILE: rtl/rtef_prep.sv
// Front pipeline: classify, clip and form the ramp numerator and divisor.
// Three register stages; depends on rtef_pkg.
module rtef_prep
   import rtef_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [VAL_W-1:0]  volume_low,
   input  logic [VAL_W-1:0]  volume_high,
   input  logic [VAL_W-1:0]  none_vol,
   input  logic [VAL_W-1:0]  full_vol,
   output logic              out_valid,
   output logic [NUM_W-1:0]  out_num,
   output logic [DIV_W-1:0]  out_den,
   output side_type          out_side
);

   // stage 1: classification
   logic              v1_ff;
   code_type          code1_ff, code1_in;
   logic [VAL_W-1:0]  lo1_ff, hi1_ff, a1_ff, b1_ff, a_eff;

   always_comb begin
      a_eff = (none_vol > full_vol) ? full_vol : none_vol;
      if (volume_low >= full_vol) begin
         code1_in = CODE_FULL;
      end else if (volume_high <= a_eff) begin
         code1_in = CODE_NONE;
      end else if (volume_high <= volume_low) begin
         code1_in = CODE_EMPTY;
      end else if (a_eff == full_vol) begin
         code1_in = CODE_STEP;
      end else begin
         code1_in = CODE_RAMP;
      end
   end

   // stage 2: clipped limits and differences
   logic              v2_ff;
   code_type          code2_ff;
   logic [VAL_W-1:0]  vl, vh, dh, dl;
   logic [VAL_W:0]    sum2_ff, sum2_in;
   logic [VAL_W-1:0]  diff2_ff, diff2_in;
   logic [DIV_W-1:0]  den2_ff, den2_in;
   logic [VAL_W-1:0]  hb2_ff, hb2_in;
   logic [VAL_W-1:0]  dlen2_ff, dlen2_in;

   always_comb begin
      vl       = (lo1_ff > a1_ff) ? lo1_ff : a1_ff;
      vh       = (hi1_ff < b1_ff) ? hi1_ff : b1_ff;
      dh       = vh - a1_ff;
      dl       = vl - a1_ff;
      sum2_in  = {1'b0, dh} + {1'b0, dl};
      diff2_in = dh - dl;
      den2_in  = {b1_ff - a1_ff, 1'b0};
      hb2_in   = (hi1_ff > b1_ff) ? (hi1_ff - b1_ff) : '0;
      dlen2_in = hi1_ff - lo1_ff;
   end

   // stage 3: numerator (dh^2 - dl^2) as one product
   logic              v3_ff;
   logic [NUM_W-1:0]  num3_ff;
   logic [NUM_W:0]    prod3_in;
   logic [DIV_W-1:0]  den3_ff;
   side_type          side3_ff;

   assign prod3_in = diff2_ff * sum2_ff;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (en) begin
         code1_ff      <= code1_in;
         lo1_ff        <= volume_low;
         hi1_ff        <= volume_high;
         a1_ff         <= a_eff;
         b1_ff         <= full_vol;
         code2_ff      <= code1_ff;
         sum2_ff       <= sum2_in;
         diff2_ff      <= diff2_in;
         den2_ff       <= den2_in;
         hb2_ff        <= hb2_in;
         dlen2_ff      <= dlen2_in;
         num3_ff       <= prod3_in[NUM_W-1:0];
         den3_ff       <= den2_ff;
         side3_ff.code <= code2_ff;
         side3_ff.hb   <= hb2_ff;
         side3_ff.dlen <= dlen2_ff;
      end
   end

   assign out_valid = v3_ff;
   assign out_num   = num3_ff;
   assign out_den   = den3_ff;
   assign out_side  = side3_ff;

endmodule

FILE: rtl/rtef_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Carries a sideband struct beside the quotient; depends on rtef_pkg.
module rtef_div
   import rtef_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [DIV_W-1:0]  in_rem,    // upper dividend bits, below in_div
   input  logic [QUO_W-1:0]  in_bits,   // lower dividend bits, MSB first
   input  logic [DIV_W-1:0]  in_div,
   input  side_type          in_side,
   output logic              out_valid,
   output logic [QUO_W-1:0]  out_quo,
   output side_type          out_side
);

   logic [QUO_W-1:0]  valid_ff;
   logic [DIV_W-1:0]  rem_ff  [QUO_W];
   logic [QUO_W-1:0]  bq_ff   [QUO_W];
   logic [DIV_W-1:0]  div_ff  [QUO_W];
   side_type          side_ff [QUO_W];

   logic [DIV_W-1:0]  st_rem  [QUO_W];
   logic [QUO_W-1:0]  st_bq   [QUO_W];
   logic [DIV_W-1:0]  st_div  [QUO_W];
   side_type          st_side [QUO_W];

   logic [DIV_W:0]    shf_c   [QUO_W];
   logic [DIV_W:0]    dif_c   [QUO_W];
   logic [DIV_W-1:0]  rem_in  [QUO_W];
   logic [QUO_W-1:0]  bq_in   [QUO_W];

   // stage inputs: first stage from the ports, the rest from the stage before
   always_comb begin
      st_rem[0]  = in_rem;
      st_bq[0]   = in_bits;
      st_div[0]  = in_div;
      st_side[0] = in_side;
      for (int s = 1; s < QUO_W; s++) begin
         st_rem[s]  = rem_ff[s-1];
         st_bq[s]   = bq_ff[s-1];
         st_div[s]  = div_ff[s-1];
         st_side[s] = side_ff[s-1];
      end
   end

   // one shift and trial subtract per stage; quotient bit enters at the LSB
   always_comb begin
      for (int s = 0; s < QUO_W; s++) begin
         shf_c[s] = {st_rem[s], st_bq[s][QUO_W-1]};
         dif_c[s] = shf_c[s] - {1'b0, st_div[s]};
         if (shf_c[s] >= {1'b0, st_div[s]}) begin
            rem_in[s] = dif_c[s][DIV_W-1:0];
            bq_in[s]  = {st_bq[s][QUO_W-2:0], 1'b1};
         end else begin
            rem_in[s] = shf_c[s][DIV_W-1:0];
            bq_in[s]  = {st_bq[s][QUO_W-2:0], 1'b0};
         end
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[QUO_W-2:0], in_valid};
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s < QUO_W; s++) begin
            rem_ff[s]  <= rem_in[s];
            bq_ff[s]   <= bq_in[s];
            div_ff[s]  <= st_div[s];
            side_ff[s] <= st_side[s];
         end
      end
   end

   assign out_valid = valid_ff[QUO_W-1];
   assign out_quo   = bq_ff[QUO_W-1];
   assign out_side  = side_ff[QUO_W-1];

endmodule

FILE: rtl/ramped_trap_exposure_fraction_top.sv
// Top level of the ramped trap exposure fraction block.
// Instantiates rtef_prep and two rtef_div; depends on rtef_pkg.
//
// One transaction per cycle is accepted and one result per cycle is
// delivered, in order, while neither req_stall nor rsp_stall holds. A
// transaction passes three front stages (classify, clip, multiply), a 17
// stage divider for the ramp integral, one stage to add the part above full
// exposure, a 17 stage divider for the normalization by the interval width,
// a result stage and the output register. A skid register behind the
// pipeline lets one more result in while rsp_stall holds; req_stall is that
// register's full flag. Configuration writes take effect on transactions
// accepted afterwards and csr_ready is always high.
module ramped_trap_exposure_fraction_top
   import rtef_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [VAL_W-1:0]      req_volume_low,
   input  logic [VAL_W-1:0]      req_volume_high,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [VAL_W-1:0]      rsp_exposed_fraction,
   output logic                  rsp_empty_interval,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [VAL_W-1:0]      csr_data
);

   logic              en;
   logic              skid_full_ff;

   // configuration registers
   logic [VAL_W-1:0]  none_vol_ff, full_vol_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         none_vol_ff <= '0;
         full_vol_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_NONE_EXPOSED: none_vol_ff <= csr_data;
            CSR_FULL_EXPOSED: full_vol_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // whole pipeline moves unless the skid register is holding a result
   assign en        = !skid_full_ff;
   assign req_stall = skid_full_ff;

   // front stages
   logic              p_valid;
   logic [NUM_W-1:0]  p_num;
   logic [DIV_W-1:0]  p_den;
   side_type          p_side;

   rtef_prep u_prep (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (req_valid),
      .volume_low  (req_volume_low),
      .volume_high (req_volume_high),
      .none_vol    (none_vol_ff),
      .full_vol    (full_vol_ff),
      .out_valid   (p_valid),
      .out_num     (p_num),
      .out_den     (p_den),
      .out_side    (p_side)
   );

   // ramp integral: num / (2(b-a)), quotient below 1.0
   logic              d1_valid;
   logic [QUO_W-1:0]  d1_quo;
   side_type          d1_side;
   logic [DIV_W-1:0]  d1_rem;

   assign d1_rem = DIV_W'(p_num[NUM_W-1:QUO_W]);

   rtef_div u_ramp_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (p_valid),
      .in_rem    (d1_rem),
      .in_bits   (p_num[QUO_W-1:0]),
      .in_div    (p_den),
      .in_side   (p_side),
      .out_valid (d1_valid),
      .out_quo   (d1_quo),
      .out_side  (d1_side)
   );

   // exposed amount: step uses the part above b alone, ramp adds it
   logic              f_valid_ff;
   logic [VAL_W-1:0]  frac_ff, frac_in;
   side_type          f_side_ff;

   always_comb begin
      if (d1_side.code == CODE_STEP) begin
         frac_in = d1_side.hb;
      end else begin
         frac_in = VAL_W'(d1_quo) + d1_side.hb;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else if (en) begin
         f_valid_ff <= d1_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         frac_ff   <= frac_in;
         f_side_ff <= d1_side;
      end
   end

   // normalization: (frac << FRAC_BITS) / (high - low)
   logic              d2_valid;
   logic [QUO_W-1:0]  d2_quo;
   side_type          d2_side;
   logic [DIV_W-1:0]  d2_rem;
   logic [QUO_W-1:0]  d2_bits;
   logic [DIV_W-1:0]  d2_div;

   assign d2_rem  = DIV_W'(frac_ff[VAL_W-1:1]);
   assign d2_bits = {frac_ff[0], {FRAC_BITS{1'b0}}};
   assign d2_div  = DIV_W'(f_side_ff.dlen);

   rtef_div u_norm_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (f_valid_ff),
      .in_rem    (d2_rem),
      .in_bits   (d2_bits),
      .in_div    (d2_div),
      .in_side   (f_side_ff),
      .out_valid (d2_valid),
      .out_quo   (d2_quo),
      .out_side  (d2_side)
   );

   // result stage: early results, empty interval, saturation at 1.0
   logic              r_valid_ff;
   logic [VAL_W-1:0]  r_res_ff, r_res_in;
   logic              r_flag_ff, r_flag_in;

   always_comb begin
      r_flag_in = 1'b0;
      case (d2_side.code)
         CODE_FULL:  r_res_in = ONE_VAL;
         CODE_NONE:  r_res_in = '0;
         CODE_EMPTY: begin
            r_res_in  = '0;
            r_flag_in = 1'b1;
         end
         default:    r_res_in = (VAL_W'(d2_quo) > ONE_VAL) ? ONE_VAL : VAL_W'(d2_quo);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r_valid_ff <= 1'b0;
      end else if (en) begin
         r_valid_ff <= d2_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r_res_ff  <= r_res_in;
         r_flag_ff <= r_flag_in;
      end
   end

   // output register with skid register behind it
   logic              push;
   logic              out_free;
   logic              rsp_valid_ff;
   logic [VAL_W-1:0]  rsp_res_ff, skid_res_ff;
   logic              rsp_flag_ff, skid_flag_ff;

   assign push     = r_valid_ff && en;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         skid_full_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= skid_full_ff || push;
         skid_full_ff <= 1'b0;
      end else if (push) begin
         skid_full_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         if (skid_full_ff) begin
            rsp_res_ff  <= skid_res_ff;
            rsp_flag_ff <= skid_flag_ff;
         end else begin
            rsp_res_ff  <= r_res_ff;
            rsp_flag_ff <= r_flag_ff;
         end
      end else if (push) begin
         skid_res_ff  <= r_res_ff;
         skid_flag_ff <= r_flag_ff;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_exposed_fraction = rsp_res_ff;
   assign rsp_empty_interval   = rsp_flag_ff;

endmodule

FILE: tb/ramped_trap_exposure_fraction_top_test.sv
// Self-checking testbench for ramped_trap_exposure_fraction_top.
// Holds a scoreboard class with its own exposure predictor and the tasks that drive the block.
// Depends on rtef_pkg and the block's rtl.
`timescale 1ns / 100ps

module ramped_trap_exposure_fraction_top_test;
   import rtef_pkg::*;

   localparam logic [VAL_W-1:0] VOL_MAX = ONE_VAL;
   localparam int IDLE_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 48;
   localparam int PHASES = 7;
   localparam int ITEMS_PER_PHASE = 100;

   // indexes with no register behind them; writes to them change nothing
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = CSR_IDX_W'(3);

   typedef struct {
      logic [VAL_W-1:0] fraction;
      logic             empty;
   } exposure_type;

   // expected exposure results, predicted at transaction acceptance
   class exposure_board;
      exposure_type     due[$];
      int               errors;
      logic [VAL_W-1:0] none_vol;
      logic [VAL_W-1:0] full_vol;

      function new();
         errors = 0;
         none_vol = '0;
         full_vol = '0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [VAL_W-1:0] val);
         if (idx == CSR_NONE_EXPOSED) begin
            none_vol = val;
         end else if (idx == CSR_FULL_EXPOSED) begin
            full_vol = val;
         end
      endfunction

      // mean exposure over [lo, hi] for the current ramp
      function exposure_type predict(logic [VAL_W-1:0] lo_v, logic [VAL_W-1:0] hi_v);
         exposure_type      r;
         longint            lo, hi, a, b, vl, vh, dh, dl, num, frac;
         longint unsigned   top, width, q;
         lo = lo_v;
         hi = hi_v;
         a = none_vol;
         b = full_vol;
         r.fraction = '0;
         r.empty = 1'b0;
         // reversed ramp collapses to a step at full exposure
         if (a > b) a = b;
         if (lo >= b) begin
            r.fraction = ONE_VAL;
         end else if (hi <= a) begin
            r.fraction = '0;
         end else if (hi <= lo) begin
            r.empty = 1'b1;
         end else begin
            if (a == b) begin
               frac = hi - b;
            end else begin
               vl = (lo > a) ? lo : a;
               vh = (hi < b) ? hi : b;
               dh = vh - a;
               dl = vl - a;
               num = dh * dh - dl * dl;
               frac = num / (2 * (b - a));
               if (hi > b) frac = frac + (hi - b);
            end
            if (frac < 0) frac = 0;
            top = frac;
            width = hi - lo;
            q = (top << FRAC_BITS) / width;
            if (q > ONE_VAL) q = ONE_VAL;
            r.fraction = q[VAL_W-1:0];
         end
         return r;
      endfunction

      function void note(logic [VAL_W-1:0] lo, logic [VAL_W-1:0] hi);
         due.push_back(predict(lo, hi));
      endfunction

      task report(string msg);
         $display("mismatch at %0t: %s", $realtime, msg);
         errors++;
      endtask

      task check(logic [VAL_W-1:0] fraction, logic empty);
         exposure_type x;
         if (due.size() == 0) begin
            report($sformatf("result fraction=%0d empty=%0b with nothing pending",
                             fraction, empty));
         end else begin
            x = due.pop_front();
            if (fraction !== x.fraction)
               report($sformatf("exposed_fraction got %0d expected %0d",
                                fraction, x.fraction));
            if (empty !== x.empty)
               report($sformatf("empty_interval got %0b expected %0b", empty, x.empty));
         end
      endtask
   endclass

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [VAL_W-1:0]     req_volume_low;
   logic [VAL_W-1:0]     req_volume_high;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [VAL_W-1:0]     rsp_exposed_fraction;
   logic                 rsp_empty_interval;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [VAL_W-1:0]     csr_data;

   exposure_board board = new();
   logic          quiet = 1'b0;
   int            idle_cycles = 0;

   ramped_trap_exposure_fraction_top u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_volume_low       (req_volume_low),
      .req_volume_high      (req_volume_high),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_exposed_fraction (rsp_exposed_fraction),
      .rsp_empty_interval   (rsp_empty_interval),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // random backpressure on the result side, none during a quiet stretch
   always @(posedge clock) begin
      rsp_stall <= quiet ? 1'b0 : ($urandom_range(0, 99) < 13);
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check(rsp_exposed_fraction, rsp_empty_interval);
   end

   // cycles without any transaction on any channel
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   // watchdog
   initial begin
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $display("FAIL");
      $finish;
   end

   function automatic logic [VAL_W-1:0] clamp_vol(int v);
      if (v < 0) return '0;
      if (v > int'(VOL_MAX)) return VOL_MAX;
      return v[VAL_W-1:0];
   endfunction

   // volume biased toward the ends of the field and the ramp corners
   function automatic logic [VAL_W-1:0] pick_vol();
      int c;
      c = $urandom_range(0, 11);
      case (c)
         0: return '0;
         1: return VOL_MAX;
         2: return board.none_vol;
         3: return board.full_vol;
         4: return clamp_vol(int'(board.none_vol) + $urandom_range(0, 2) - 1);
         5: return clamp_vol(int'(board.full_vol) + $urandom_range(0, 2) - 1);
         default: return VAL_W'($urandom_range(0, int'(VOL_MAX)));
      endcase
   endfunction

   // one register write; the caller lowers csr_valid after the last one
   task write_reg(logic [CSR_IDX_W-1:0] idx, logic [VAL_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      board.set_reg(idx, val);
   endtask

   task configure(logic [VAL_W-1:0] none_v, logic [VAL_W-1:0] full_v, bit spare);
      write_reg(CSR_NONE_EXPOSED, none_v);
      write_reg(CSR_FULL_EXPOSED, full_v);
      if (spare) begin
         write_reg(CSR_SPARE_LO, VAL_W'($urandom_range(0, int'(VOL_MAX))));
         write_reg(CSR_SPARE_HI, VAL_W'($urandom_range(0, int'(VOL_MAX))));
      end
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // one request transaction, with random idle cycles ahead of it unless quiet
   task send_item(logic [VAL_W-1:0] lo, logic [VAL_W-1:0] hi);
      while (!quiet && $urandom_range(0, 99) < 13) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_volume_low <= lo;
      req_volume_high <= hi;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note(lo, hi);
   endtask

   task send_random();
      logic [VAL_W-1:0] x, y, t;
      int               kind;
      x = pick_vol();
      y = pick_vol();
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
         // well-formed interval
         if (x > y) begin
            t = x;
            x = y;
            y = t;
         end
      end else if (kind < 80) begin
         y = x;
      end else if (kind < 90) begin
         if (x < y) begin
            t = x;
            x = y;
            y = t;
         end
      end
      send_item(x, y);
   endtask

   // let the pipeline empty before touching the registers
   task drain();
      req_valid <= 1'b0;
      while (board.due.size() != 0) @(posedge clock);
   endtask

   initial begin
      logic [VAL_W-1:0] a, b, t;
      int               sel;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_volume_low <= '0;
      req_volume_high <= '0;
      csr_valid <= 1'b0;
      csr_index <= CSR_NONE_EXPOSED;
      csr_data <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: step at zero
      send_item('0, '0);
      send_item('0, VOL_MAX);
      send_item(VOL_MAX, '0);
      drain();

      // ordinary ramp: early full, early none, empty, reversed, ramp cases
      configure(17'd16384, 17'd49152, 1'b1);
      send_item(17'd49152, VOL_MAX);
      send_item('0, 17'd16384);
      send_item(17'd20000, 17'd20000);
      send_item(17'd40000, 17'd30000);
      send_item(17'd20000, 17'd40000);
      send_item('0, VOL_MAX);
      send_item(17'd30000, VOL_MAX);
      send_item(17'd1000, 17'd30000);
      drain();

      // equal limits give a step
      configure(17'd32768, 17'd32768, 1'b0);
      send_item(17'd10000, 17'd40000);
      send_item('0, 17'd32768);
      send_item(17'd32767, 17'd32769);
      drain();

      // none above full: step at the full volume
      configure(17'd60000, 17'd20000, 1'b0);
      send_item(17'd10000, 17'd30000);
      send_item(17'd19999, 17'd20000);
      drain();

      // extremes of the registers
      configure('0, VOL_MAX, 1'b0);
      send_item('0, VOL_MAX);
      send_item(17'd65535, VOL_MAX);
      drain();
      configure(VOL_MAX, VOL_MAX, 1'b0);
      send_item('0, VOL_MAX);
      send_item(VOL_MAX, VOL_MAX);
      drain();
      configure('0, 17'd1, 1'b0);
      send_item('0, 17'd1);
      send_item('0, 17'd2);
      drain();

      // random settings, each with a batch of random intervals
      for (int p = 0; p < PHASES; p++) begin
         a = VAL_W'($urandom_range(0, int'(VOL_MAX)));
         b = VAL_W'($urandom_range(0, int'(VOL_MAX)));
         sel = $urandom_range(0, 5);
         case (sel)
            0: b = a;
            1: begin
               if (a < b) begin
                  t = a;
                  a = b;
                  b = t;
               end
            end
            2: begin
               a = '0;
               b = VOL_MAX;
            end
            default: begin
               if (a > b) begin
                  t = a;
                  a = b;
                  b = t;
               end
            end
         endcase
         configure(a, b, p[0]);
         quiet <= (p == 3);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) send_random();
         drain();
         quiet <= 1'b0;
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
